FILE: rtl/linear_probe_hash_table_macros.svh
// Assertion macros for the hash table block.
// Used by the modules that carry concurrent assertions.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define LPHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/lpht_pkg.sv
// Package for the hash table block: operation codes, state encoding and
// the request record passed from front to back. No dependencies.
package lpht_pkg;

  // Table size; a power of two, so the home slot is the low bits of the hash.
  localparam int unsigned SLOTS = 64;
  localparam int unsigned IN_KEY_W = 32;
  localparam int unsigned IN_HASH_W = 32;
  localparam int unsigned IN_VAL_W = 32;
  localparam int unsigned LIVE_W = 7;
  localparam int unsigned LIMIT_W = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd75;
  localparam int unsigned PERCENT = 100;

  typedef enum logic [1:0] {
    KIND_SET    = 2'd0,
    KIND_GET    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_WRITE,
    ST_CLEAR,
    ST_OUT
  } state_t;

  // One request as it leaves the front part.
  typedef struct packed {
    kind_t                kind;
    logic [IN_KEY_W-1:0]  key;
    logic [IN_HASH_W-1:0] hash_word;
    logic [IN_VAL_W-1:0]  value;
  } req_t;

endpackage

FILE: rtl/lpht_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on lpht_pkg.
interface lpht_req_if;
  import lpht_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic [IN_KEY_W-1:0] key;
  logic [IN_HASH_W-1:0] hash_word;
  logic [IN_VAL_W-1:0] value;
  modport source (output valid, kind, key, hash_word, value, input ready);
  modport sink (input valid, kind, key, hash_word, value, output ready);
endinterface

interface lpht_rsp_if;
  import lpht_pkg::*;
  logic valid;
  logic ready;
  logic found;
  logic [IN_VAL_W-1:0] result_value;
  logic status;
  logic [LIVE_W-1:0] live_entries;
  modport source (output valid, found, result_value, status, live_entries, input ready);
  modport sink (input valid, found, result_value, status, live_entries, output ready);
endinterface

FILE: rtl/lpht_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module lpht_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/lpht_front.sv
// Front part: accepts request items into a two-entry queue.
// Depends on lpht_pkg and lpht_if.
module lpht_front (
  input  logic            clk,
  input  logic            rst_n,
  lpht_req_if.sink        in_ch,
  output lpht_pkg::req_t  q_req,
  output logic            q_valid,
  input  logic            q_pop
);
  import lpht_pkg::*;

  req_t       buf_r [2];
  logic       rd_r, rd_nxt;
  logic       wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_req = buf_r[rd_r];

  // Queue pointers and count.
  always_comb begin
    rd_nxt = rd_r ^ (q_pop && q_valid);
    wr_nxt = wr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Payload storage.
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_r] <= '{kind: kind_t'(in_ch.kind), key: in_ch.key,
                       hash_word: in_ch.hash_word, value: in_ch.value};
    end
  end
endmodule

FILE: rtl/lpht_back.sv
// Back part: probes the slot memories one slot per pass and writes results.
// Depends on lpht_pkg, lpht_if, lpht_ram and the assertion macros.
module lpht_back #(
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [lpht_pkg::LIMIT_W-1:0] limit,
  input  lpht_pkg::req_t               q_req,
  input  logic                         q_valid,
  output logic                         q_pop,
  lpht_rsp_if.source                   out_ch
);
  import lpht_pkg::*;
  `include "linear_probe_hash_table_macros.svh"

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned NW = CW + 7;
  localparam int unsigned CAPW = IW + 1 + LIMIT_W;

  state_t state_r, state_nxt;
  logic [SLOTS-1:0] occ_r, occ_nxt, del_r, del_nxt;
  logic [CW-1:0] live_r, live_nxt, dcnt_r, dcnt_nxt;
  req_t req_r, req_nxt;
  logic [IW-1:0] idx_r, idx_nxt, free_r, free_nxt;
  logic free_ok_r, free_ok_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [NW-1:0] need_r, need_nxt;
  logic [CAPW-1:0] cap_r, cap_nxt;
  logic found_r, found_nxt, status_r, status_nxt;
  logic [IN_VAL_W-1:0] res_r, res_nxt;
  logic hit_r, hit_nxt;
  logic out_v_r, out_v_nxt;

  logic [KEY_BITS-1:0] rd_key, key_m;
  logic [IN_HASH_W-1:0] rd_hash;
  logic [VALUE_BITS-1:0] rd_val, val_m;
  logic we, we_kh;
  logic [VALUE_BITS-1:0] wval;

  assign key_m = KEY_BITS'(req_r.key);
  assign val_m = VALUE_BITS'(req_r.value);

  lpht_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key (
    .clk(clk), .we(we_kh), .waddr(idx_r), .wdata(key_m), .raddr(idx_r), .rdata(rd_key));
  lpht_ram #(.WIDTH(IN_HASH_W), .DEPTH(SLOTS)) u_hash (
    .clk(clk), .we(we_kh), .waddr(idx_r), .wdata(req_r.hash_word), .raddr(idx_r),
    .rdata(rd_hash));
  lpht_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_val (
    .clk(clk), .we(we), .waddr(idx_r), .wdata(wval), .raddr(idx_r), .rdata(rd_val));

  assign out_ch.valid = out_v_r;
  assign out_ch.found = found_r;
  assign out_ch.result_value = res_r;
  assign out_ch.status = status_r;
  assign out_ch.live_entries = LIVE_W'(live_r);

  // Sequencer: read a slot, check it, step or finish.
  always_comb begin
    state_nxt = state_r;
    occ_nxt = occ_r; del_nxt = del_r;
    live_nxt = live_r; dcnt_nxt = dcnt_r;
    req_nxt = req_r; idx_nxt = idx_r; free_nxt = free_r; free_ok_nxt = free_ok_r;
    n_nxt = n_r; need_nxt = need_r; cap_nxt = cap_r;
    found_nxt = found_r; status_nxt = status_r; res_nxt = res_r;
    hit_nxt = hit_r; out_v_nxt = out_v_r;
    q_pop = 1'b0; we = 1'b0; we_kh = 1'b0; wval = val_m;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && !out_v_r) begin
          q_pop = 1'b1;
          req_nxt = q_req;
          idx_nxt = IW'(q_req.hash_word);
          n_nxt = '0;
          free_ok_nxt = 1'b0;
          found_nxt = 1'b0; status_nxt = 1'b0; res_nxt = '0; hit_nxt = 1'b0;
          need_nxt = NW'((live_r + dcnt_r + 1'b1) * PERCENT);
          cap_nxt = CAPW'(SLOTS) * CAPW'(limit);
          state_nxt = (q_req.kind == KIND_CLEAR) ? ST_CLEAR : ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!occ_r[idx_r] || n_r == CW'(SLOTS)) begin
          state_nxt = ST_WRITE;
        end else if (!del_r[idx_r] && rd_hash == req_r.hash_word && rd_key == key_m) begin
          hit_nxt = 1'b1;
          found_nxt = 1'b1;
          res_nxt = IN_VAL_W'(rd_val);
          state_nxt = ST_WRITE;
        end else begin
          if (del_r[idx_r] && !free_ok_r) begin
            free_ok_nxt = 1'b1;
            free_nxt = idx_r;
          end
          idx_nxt = (idx_r == IW'(SLOTS - 1)) ? '0 : idx_r + 1'b1;
          n_nxt = n_r + 1'b1;
          state_nxt = ST_READ;
        end
        // First empty slot closes the free search if no tombstone was seen.
        if (!occ_r[idx_r] && n_r != CW'(SLOTS) && !free_ok_r) begin
          free_ok_nxt = 1'b1;
          free_nxt = idx_r;
        end
      end
      ST_WRITE: begin
        state_nxt = ST_OUT;
        if (hit_r) begin
          if (req_r.kind == KIND_SET) begin
            we = 1'b1;
          end else if (req_r.kind == KIND_REMOVE) begin
            we = 1'b1; wval = '0;
            del_nxt[idx_r] = 1'b1;
            live_nxt = live_r - 1'b1;
            dcnt_nxt = dcnt_r + 1'b1;
          end
        end else if (req_r.kind == KIND_SET) begin
          if (NW'(need_r) > NW'(cap_r) || !free_ok_r) begin
            status_nxt = 1'b1;
          end else begin
            idx_nxt = free_r;
            state_nxt = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        state_nxt = ST_OUT;
        if (req_r.kind == KIND_CLEAR) begin
          occ_nxt = '0; del_nxt = '0; live_nxt = '0; dcnt_nxt = '0;
        end else begin
          // Insert a new key at the chosen slot.
          we = 1'b1; we_kh = 1'b1;
          if (occ_r[idx_r] && del_r[idx_r]) dcnt_nxt = dcnt_r - 1'b1;
          occ_nxt[idx_r] = 1'b1;
          del_nxt[idx_r] = 1'b0;
          live_nxt = live_r + 1'b1;
        end
      end
      ST_OUT: begin
        out_v_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (out_v_r && out_ch.ready) out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      occ_r <= '0; del_r <= '0;
      live_r <= '0; dcnt_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r <= occ_nxt; del_r <= del_nxt;
      live_r <= live_nxt; dcnt_r <= dcnt_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt; idx_r <= idx_nxt; free_r <= free_nxt; free_ok_r <= free_ok_nxt;
    n_r <= n_nxt; need_r <= need_nxt; cap_r <= cap_nxt;
    found_r <= found_nxt; status_r <= status_nxt; res_r <= res_nxt; hit_r <= hit_nxt;
  end

  // Consistency checks.
  `LPHT_ASSERT_IMP(a_live_le, clk, rst_n, 1'b1, (live_r + dcnt_r) <= CW'(SLOTS))
  `LPHT_ASSERT_IMP(a_found_status, clk, rst_n, out_v_r, !(found_r && status_r))
  `LPHT_ASSERT_NEXT(a_pop_idle, clk, rst_n, q_pop, state_r != ST_IDLE)
endmodule

FILE: rtl/linear_probe_hash_table.sv
// Top level of the linear probing hash table.
// Depends on lpht_pkg, lpht_if, lpht_front and lpht_back.
//
//   channel | dir | contents
//   in_     | in  | kind, key, hash_word, value
//   out_    | out | found, result_value, status, live_entries
//   cfg_    | in  | load_limit_percent write
//
// Each probed slot takes a memory read, then a compare, on the single read
// port. A get, remove or overwrite pops, probes, writes, registers the
// output and hands it off; a new-key insert adds an insert step, and a clear
// pops, clears and outputs. A miss on a full table probes SLOTS + 1 slots.
// Reset is synchronous; it clears valid bits, counts and the queue, and
// loads the limit register with 75.
// The front queue holds two items; while a result waits, the back part holds
// and the input keeps accepting until the queue is full.
module linear_probe_hash_table #(
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  lpht_req_if.sink                     in_ch,
  lpht_rsp_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [lpht_pkg::LIMIT_W-1:0] cfg_wdata
);
  import lpht_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  req_t q_req;
  logic q_valid, q_pop;

  // Load limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  lpht_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .q_req(q_req), .q_valid(q_valid),
    .q_pop(q_pop));

  lpht_back #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .limit(limit_r), .q_req(q_req), .q_valid(q_valid),
    .q_pop(q_pop), .out_ch(out_ch));
endmodule
